>>> rtl/tcpu_pkg.sv
`default_nettype none

package tcpu_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned RIDX_W    = 4;

  // Opcodes taken from the high nibble of the instruction byte.
  localparam logic [3:0] OP_LOAD = 4'h1;
  localparam logic [3:0] OP_ADD  = 4'h2;
  localparam logic [3:0] OP_SUB  = 4'h3;
  localparam logic [3:0] OP_HALT = 4'hF;

  localparam logic [2:0] ST_WRITTEN  = 3'd0;
  localparam logic [2:0] ST_EXECUTED = 3'd1;
  localparam logic [2:0] ST_HALT     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;

  localparam logic REQ_LOAD = 1'b0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] load_address;
    logic [7:0] load_data;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        next_pc;
    logic              dest_written;
    logic [RIDX_W-1:0] dest_index;
    logic [7:0]        dest_value;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/tiny_register_cpu_step.sv
`default_nettype none
// A program byte write or a step while halted gives its result beat in the cycle after
// it is accepted; other steps pass through FETCH (halt, unknown opcode), FETCH and ARG (LOAD),
// or FETCH, ARG and SRC (ADD, SUB) before their result beat is registered. One item at a time;
// the single read port of each memory sets the sequence fetch, operand, source register.
// Reset: program counter, halt flag and the valid bits of both memories clear at once, so every
// memory byte and register reads as zero until written.
module tiny_register_cpu_step
  import tcpu_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_ARG   = 2'd2;
  localparam logic [1:0] S_SRC   = 2'd3;

  // Byte address reduced modulo the memory depth, worked out at elaboration.
  logic [AW-1:0] mod_tbl [256];
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = AW'(g % MEM_DEPTH);
  end

  logic [1:0]        state_q, state_d;
  logic [7:0]        pc_q, pc_d;
  logic              halted_q, halted_d;
  logic [3:0]        op_q, op_d;
  logic [RIDX_W-1:0] rd_q, rd_d;
  logic [7:0]        dst_val_q, dst_val_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q;
  out_t              res;
  logic              res_load;

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld_q;
  logic                 mem_rd_vld_q;
  logic [7:0]           mem_rd_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [7:0]           mem_byte;

  logic [7:0]           rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_q;
  logic                 rf_rd_vld_q;
  logic [7:0]           rf_rd_q;
  logic                 rf_we, rf_re;
  logic [RIDX_W-1:0]    rf_wa, rf_ra;
  logic [7:0]           rf_wd;
  logic [7:0]           rf_byte;
  logic [7:0]           sum;

  logic in_acc;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mem_byte = mem_rd_vld_q ? mem_rd_q : 8'h00;
  assign rf_byte  = rf_rd_vld_q ? rf_rd_q : 8'h00;
  assign sum      = (op_q == OP_ADD) ? (dst_val_q + rf_byte) : (dst_val_q - rf_byte);
  assign mem_wa   = mod_tbl[in_data_i.load_address];

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    halted_d    = halted_q;
    op_d        = op_q;
    rd_d        = rd_q;
    dst_val_d   = dst_val_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_ra      = mod_tbl[pc_q];
    rf_we       = 1'b0;
    rf_re       = 1'b0;
    rf_ra       = rd_q;
    rf_wa       = rd_q;
    rf_wd       = mem_byte;
    res_load    = 1'b0;
    res         = '0;
    res.next_pc = pc_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.req_type == REQ_LOAD) begin
            mem_we     = 1'b1;
            res_load   = 1'b1;
            res.status = ST_WRITTEN;
          end else if (halted_q) begin
            res_load   = 1'b1;
            res.status = ST_IGNORED;
          end else begin
            mem_re  = 1'b1;
            pc_d    = pc_q + 8'd1;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        op_d = mem_byte[7:4];
        rd_d = mem_byte[3:0];
        if (mem_byte[7:4] == OP_LOAD || mem_byte[7:4] == OP_ADD ||
            mem_byte[7:4] == OP_SUB) begin
          mem_re  = 1'b1;
          pc_d    = pc_q + 8'd1;
          rf_re   = 1'b1;
          rf_ra   = mem_byte[3:0];
          state_d = S_ARG;
        end else if (mem_byte[7:4] == OP_HALT) begin
          halted_d   = 1'b1;
          res_load   = 1'b1;
          res.status = ST_HALT;
          state_d    = S_IDLE;
        end else begin
          res_load   = 1'b1;
          res.status = ST_UNKNOWN;
          state_d    = S_IDLE;
        end
      end
      S_ARG: begin
        if (op_q == OP_LOAD) begin
          rf_we            = 1'b1;
          rf_wd            = mem_byte;
          res_load         = 1'b1;
          res.status       = ST_EXECUTED;
          res.dest_written = 1'b1;
          res.dest_index   = rd_q;
          res.dest_value   = mem_byte;
          state_d          = S_IDLE;
        end else begin
          // Only the low nibble of the operand byte names the source register.
          dst_val_d = rf_byte;
          rf_re     = 1'b1;
          rf_ra     = mem_byte[3:0];
          state_d   = S_SRC;
        end
      end
      S_SRC: begin
        rf_we            = 1'b1;
        rf_wd            = sum;
        res_load         = 1'b1;
        res.status       = ST_EXECUTED;
        res.dest_written = 1'b1;
        res.dest_index   = rd_q;
        res.dest_value   = sum;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && out_stall_i) || res_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= 8'h00;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      mem_vld_q    <= '0;
      mem_rd_vld_q <= 1'b0;
      rf_vld_q     <= '0;
      rf_rd_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        mem_vld_q[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        mem_rd_vld_q <= mem_vld_q[mem_ra];
      end
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
      if (rf_re) begin
        rf_rd_vld_q <= rf_vld_q[rf_ra];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    rd_q      <= rd_d;
    dst_val_q <= dst_val_d;
    if (res_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= in_data_i.load_data;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (rf_re) begin
      rf_rd_q <= rf[rf_ra];
    end
  end

endmodule

`default_nettype wire
